// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge, disabled during reset.
`define AST_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication checked on the following edge, disabled during reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/hci_pkg.sv =====
`timescale 1ns / 1ps

package hci_pkg;

	// mode codes; the unused code is summed as plain
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_UDP   = 2'd1;
	localparam logic [1:0] MODE_TCP   = 2'd2;

	localparam logic [15:0] PROTO_UDP   = 16'd17;
	localparam logic [15:0] PROTO_TCP   = 16'd6;
	localparam logic [15:0] PSEUDO_BIAS = 16'd8;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

	// packet snapshot taken on the last byte
	typedef struct packed {
		logic [15:0] sum;
		logic [15:0] pad_word;
		logic [1:0]  mode;
		logic [15:0] count;
		logic        overflow;
	} hci_snap_t;

	// ones' complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		logic [16:0] f;
		s = {1'b0, a} + {1'b0, b};
		f = {1'b0, s[15:0]} + {16'd0, s[16]};
		return f[15:0];
	endfunction

endpackage

// ===== hdl/hci_if.sv =====
`timescale 1ns / 1ps

interface hci_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [1:0] mode;
	logic       last;

	modport source (output valid, output data_byte, output mode, output last, input ready);
	modport sink (input valid, input data_byte, input mode, input last, output ready);
endinterface

interface hci_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum_value;
	logic [15:0] byte_total;
	logic        too_long;

	modport source (output valid, output checksum_value, output byte_total, output too_long,
		input ready);
	modport sink (input valid, input checksum_value, input byte_total, input too_long,
		output ready);
endinterface

// ===== hdl/hci_accum.sv =====
`timescale 1ns / 1ps

module hci_accum
	import hci_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hci_byte_if.sink  pkt,
	input  logic      s1_ready,
	output logic      s1_valid,
	output hci_snap_t snap_s1
);

	logic [15:0] sum_q;
	logic [7:0]  held_q;
	logic        odd_q;
	logic [1:0]  mode_q;
	logic [15:0] cnt_q;
	logic        in_pkt_q;
	logic        ovf_q;

	logic [15:0] sum_nxt;
	logic [7:0]  held_nxt;
	logic        odd_nxt;
	logic [1:0]  mode_nxt;
	logic [15:0] cnt_nxt;
	logic        ovf_nxt;
	logic        cnt_sat;
	logic        accept;

	assign pkt.ready = !s1_valid || s1_ready;
	assign accept    = pkt.valid && pkt.ready;

	always_comb begin
		mode_nxt = in_pkt_q ? mode_q : pkt.mode;
		cnt_sat  = (cnt_q == COUNT_MAX);
		cnt_nxt  = cnt_sat ? cnt_q : cnt_q + 16'd1;
		ovf_nxt  = ovf_q | cnt_sat;
		sum_nxt  = odd_q ? oc_add(sum_q, {held_q, pkt.data_byte}) : sum_q;
		held_nxt = odd_q ? held_q : pkt.data_byte;
		odd_nxt  = ~odd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			held_q   <= '0;
			odd_q    <= 1'b0;
			mode_q   <= MODE_PLAIN;
			cnt_q    <= '0;
			in_pkt_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			if (pkt.last) begin
				sum_q    <= '0;
				held_q   <= '0;
				odd_q    <= 1'b0;
				mode_q   <= MODE_PLAIN;
				cnt_q    <= '0;
				in_pkt_q <= 1'b0;
				ovf_q    <= 1'b0;
			end else begin
				sum_q    <= sum_nxt;
				held_q   <= held_nxt;
				odd_q    <= odd_nxt;
				mode_q   <= mode_nxt;
				cnt_q    <= cnt_nxt;
				in_pkt_q <= 1'b1;
				ovf_q    <= ovf_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept && pkt.last) begin
			s1_valid <= 1'b1;
		end else if (s1_ready) begin
			s1_valid <= 1'b0;
		end
	end

	// snapshot payload, no reset
	always_ff @(posedge clk) begin
		if (accept && pkt.last) begin
			snap_s1.sum      <= sum_nxt;
			snap_s1.pad_word <= odd_nxt ? {held_nxt, 8'h00} : 16'h0000;
			snap_s1.mode     <= mode_nxt;
			snap_s1.count    <= cnt_nxt;
			snap_s1.overflow <= ovf_nxt;
		end
	end

endmodule

// ===== hdl/hci_final.sv =====
`timescale 1ns / 1ps

module hci_final
	import hci_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s1_valid,
	input  hci_snap_t   snap_s1,
	output logic        s1_ready,
	hci_result_if.source res
);

	logic        out_valid_q;
	logic [15:0] csum_q;
	logic [15:0] total_q;
	logic        long_q;

	logic [15:0] term;
	logic [17:0] raw;
	logic [16:0] fold1;
	logic [16:0] fold2;

	assign s1_ready = !out_valid_q || res.ready;

	// three-term sum, then two end-around folds
	always_comb begin
		case (snap_s1.mode)
			MODE_UDP: term = snap_s1.count + PROTO_UDP - PSEUDO_BIAS;
			MODE_TCP: term = snap_s1.count + PROTO_TCP - PSEUDO_BIAS;
			default:  term = 16'h0000;
		endcase
		raw   = {2'b00, snap_s1.sum} + {2'b00, snap_s1.pad_word} + {2'b00, term};
		fold1 = {1'b0, raw[15:0]} + {15'd0, raw[17:16]};
		fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_ready) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_ready) begin
			csum_q  <= ~fold2[15:0];
			total_q <= snap_s1.count;
			long_q  <= snap_s1.overflow;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.checksum_value = csum_q;
	assign res.byte_total     = total_q;
	assign res.too_long       = long_q;

endmodule

// ===== hdl/internet_checksum_pseudo_hdr_top.sv =====
// Channel  Dir  Payload                                   Transfer
// pkt      in   data_byte[7:0], mode[1:0], last           valid && ready
// res      out  checksum_value[15:0], byte_total[15:0],   valid && ready
//               too_long
//
// One byte is taken per cycle while pkt.ready is high; the running state
// updates on each transfer. A byte marked last lands in a snapshot register;
// the result then passes through the finishing stage and the output register.
// pkt.ready drops only while a snapshot waits behind a stalled result.
// Reset (arst_n low) clears all packet state; the next byte starts a packet.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module internet_checksum_pseudo_hdr_top
	import hci_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	hci_byte_if.sink     pkt,
	hci_result_if.source res
);

	// handoff between the accumulator and the finishing stage
	logic      s1_valid;
	logic      s1_ready;
	hci_snap_t snap_s1;

	// accumulator: pairs bytes big-endian, end-around add, counts bytes,
	// latches mode on the first byte, snapshots on last
	hci_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt      (pkt),
		.s1_ready (s1_ready),
		.s1_valid (s1_valid),
		.snap_s1  (snap_s1)
	);

	// finishing stage: odd-byte pad plus pseudo-header length term, fold,
	// complement, output register
	hci_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.snap_s1  (snap_s1),
		.s1_ready (s1_ready),
		.res      (res)
	);

	// a last-byte transfer always leaves a snapshot pending
	`AST_NEXT(a_last_snap, clk, arst_n, pkt.valid && pkt.ready && pkt.last, s1_valid)
	// input stalls only behind a pending snapshot and a stalled result
	`AST_SAME(a_stall_cause, clk, arst_n, !pkt.ready, s1_valid && res.valid && !res.ready)
	// too-long results carry the saturated count
	`AST_SAME(a_long_sat, clk, arst_n, res.valid && res.too_long, res.byte_total == COUNT_MAX)

endmodule
